// ===== src/dpb_pkg.sv =====
// shared types and constants for the depth pixel back-projection block
package dpb_pkg;

    localparam int STAGES = 6;

    localparam logic [7:0]  MASK_THRESHOLD = 8'd10;
    localparam logic [48:0] ROUND_HALF     = 49'h000_0800_0000;
    localparam logic [23:0] POS_LIMIT      = 24'h7F_FFFF;
    localparam logic [23:0] NEG_LIMIT      = 24'h80_0000;

    localparam logic [23:0] RST_METERS_PER_UNIT = 24'd16777;
    localparam logic        RST_MASK_ENABLE     = 1'b1;
    localparam logic [23:0] RST_CLIP_MAX_Z      = 24'd196608;
    localparam logic [15:0] RST_CENTER_X        = 16'd10240;
    localparam logic [15:0] RST_CENTER_Y        = 16'd5760;
    localparam logic [23:0] RST_INV_FOCAL_X     = 24'd18641;
    localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd18641;

    typedef enum logic [2:0] {
        REG_METERS_PER_UNIT = 3'd0,
        REG_MASK_ENABLE     = 3'd1,
        REG_CLIP_MAX_Z      = 3'd2,
        REG_CENTER_X        = 3'd3,
        REG_CENTER_Y        = 3'd4,
        REG_INV_FOCAL_X     = 3'd5,
        REG_INV_FOCAL_Y     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] depth_raw;
        logic [7:0]  mask_value;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [23:0]        point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } out_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [23:0] z;
        rgb_t        rgb;
    } pass_t;

    typedef struct packed {
        logic [STAGES-1:0] adv;
    } pipe_ctrl_t;

endpackage

// ===== src/depth_pixel_backprojection.sv =====
// top level of the depth pixel back-projection pipeline
//
//   channel   ports                              direction  content
//   -------   --------------------------------   ---------  ------------------------------
//   input     s_valid, s_ready, s_data           in         one depth pixel with mask, rgb
//   result    m_valid, m_ready, m_data           out        one 3d point with rgb
//   config    cfg_wr_en, cfg_index, cfg_data     in         register writes, no read-back
//
// one request per clock sustained while m_ready is held high; m_valid and m_data come from the last stage
// six register stages: depth multiply, round and clip, offset times depth, split
// multiply by the focal reciprocal, rounding add, saturation into the output register
// masked, zero-depth and clipped pixels drop out as bubbles and produce no result
// a stage advances when empty or when the next advances; stalls back up, bubbles squeeze out
// aresetn (synchronous) clears the valid bits and loads the register defaults
module depth_pixel_backprojection #(
    parameter int DEPTH_BITS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dpb_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dpb_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import dpb_pkg::*;

    // offset magnitude width: shifted pixel index or 16-bit principal point
    localparam int MAG_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;

    // configuration registers
    logic [23:0] meters_per_unit_reg;
    logic        mask_enable_reg;
    logic [23:0] clip_max_z_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [23:0] inv_focal_x_reg;
    logic [23:0] inv_focal_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meters_per_unit_reg <= RST_METERS_PER_UNIT;
            mask_enable_reg     <= RST_MASK_ENABLE;
            clip_max_z_reg      <= RST_CLIP_MAX_Z;
            center_x_reg        <= RST_CENTER_X;
            center_y_reg        <= RST_CENTER_Y;
            inv_focal_x_reg     <= RST_INV_FOCAL_X;
            inv_focal_y_reg     <= RST_INV_FOCAL_Y;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_METERS_PER_UNIT: meters_per_unit_reg <= cfg_data;
                REG_MASK_ENABLE:     mask_enable_reg     <= cfg_data[0];
                REG_CLIP_MAX_Z:      clip_max_z_reg      <= cfg_data;
                REG_CENTER_X:        center_x_reg        <= cfg_data[15:0];
                REG_CENTER_Y:        center_y_reg        <= cfg_data[15:0];
                REG_INV_FOCAL_X:     inv_focal_x_reg     <= cfg_data;
                REG_INV_FOCAL_Y:     inv_focal_y_reg     <= cfg_data;
                default: ;  // index past the register list is ignored
            endcase
        end
    end

    // pipeline control: valid bits and per-stage advance
    pipe_ctrl_t        ctrl;
    logic [STAGES-1:0] valid_reg, valid_next;
    logic              mask_pass, z_pass;

    always_comb begin
        // last stage is the output register
        ctrl.adv[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            ctrl.adv[i] = !valid_reg[i] || ctrl.adv[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        // masked pixels never enter, out-of-range depths drop at stage two
        if (ctrl.adv[0]) valid_next[0] = s_valid && mask_pass;
        if (ctrl.adv[1]) valid_next[1] = valid_reg[0] && z_pass;
        for (int i = 2; i < STAGES; i++) begin
            if (ctrl.adv[i]) valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = ctrl.adv[0];
    assign m_valid = valid_reg[STAGES-1];

    // front: depth scaling and pixel offsets
    logic [23:0]      z_front;
    logic [MAG_W-1:0] mag_x, mag_y;
    logic             neg_x, neg_y;
    rgb_t             rgb_front;

    dpb_front #(
        .DEPTH_BITS (DEPTH_BITS),
        .COORD_BITS (COORD_BITS),
        .MAG_W      (MAG_W)
    ) u_front (
        .aclk            (aclk),
        .ctrl            (ctrl),
        .in_data         (s_data),
        .meters_per_unit (meters_per_unit_reg),
        .mask_enable     (mask_enable_reg),
        .clip_max_z      (clip_max_z_reg),
        .center_x        (center_x_reg),
        .center_y        (center_y_reg),
        .mask_pass       (mask_pass),
        .z_pass          (z_pass),
        .z_out           (z_front),
        .mag_x           (mag_x),
        .neg_x           (neg_x),
        .mag_y           (mag_y),
        .neg_y           (neg_y),
        .rgb_out         (rgb_front)
    );

    // x and y lanes, stages three through six
    logic signed [23:0] point_x, point_y;

    dpb_lateral #(.MAG_W(MAG_W)) u_lane_x (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .mag_in    (mag_x),
        .neg_in    (neg_x),
        .z_in      (z_front),
        .inv_focal (inv_focal_x_reg),
        .coord_out (point_x)
    );

    dpb_lateral #(.MAG_W(MAG_W)) u_lane_y (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .mag_in    (mag_y),
        .neg_in    (neg_y),
        .z_in      (z_front),
        .inv_focal (inv_focal_y_reg),
        .coord_out (point_y)
    );

    // z and colour ride alongside the lanes
    pass_t pass_reg [2:STAGES-1];

    always_ff @(posedge aclk) begin
        if (ctrl.adv[2]) pass_reg[2] <= '{z: z_front, rgb: rgb_front};
        for (int i = 3; i < STAGES; i++) begin
            if (ctrl.adv[i]) pass_reg[i] <= pass_reg[i-1];
        end
    end

    always_comb begin
        m_data.point_x   = point_x;
        m_data.point_y   = point_y;
        m_data.point_z   = pass_reg[STAGES-1].z;
        m_data.red_out   = pass_reg[STAGES-1].rgb.red;
        m_data.green_out = pass_reg[STAGES-1].rgb.green;
        m_data.blue_out  = pass_reg[STAGES-1].rgb.blue;
    end

endmodule

// ===== src/dpb_front.sv =====
// front stages: depth scaling, mask test, clip test and pixel offsets from the principal point
module dpb_front #(
    parameter int DEPTH_BITS = 16,
    parameter int COORD_BITS = 12,
    parameter int MAG_W      = 16
) (
    input  logic                 aclk,
    input  dpb_pkg::pipe_ctrl_t  ctrl,
    input  dpb_pkg::in_item_t    in_data,
    input  logic [23:0]          meters_per_unit,
    input  logic                 mask_enable,
    input  logic [23:0]          clip_max_z,
    input  logic [15:0]          center_x,
    input  logic [15:0]          center_y,
    output logic                 mask_pass,
    output logic                 z_pass,
    output logic [23:0]          z_out,
    output logic [MAG_W-1:0]     mag_x,
    output logic                 neg_x,
    output logic [MAG_W-1:0]     mag_y,
    output logic                 neg_y,
    output dpb_pkg::rgb_t        rgb_out
);
    import dpb_pkg::*;

    localparam int PROD_W = DEPTH_BITS + 24;
    localparam int ZF_W   = DEPTH_BITS + 16;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W-1:0]  mag_x1_reg, mag_y1_reg, mag_x1_next, mag_y1_next;
    logic              neg_x1_reg, neg_y1_reg, neg_x1_next, neg_y1_next;
    rgb_t              rgb1_reg, rgb1_next;

    logic [23:0]       z2_reg, z2_next;
    logic [MAG_W-1:0]  mag_x2_reg, mag_y2_reg;
    logic              neg_x2_reg, neg_y2_reg;
    rgb_t              rgb2_reg;

    logic [MAG_W-1:0]  pos_x, pos_y, cx, cy;
    logic [PROD_W-1:0] rounded;
    logic [ZF_W-1:0]   z_full;

    // stage 1
    always_comb begin
        mask_pass = !(mask_enable && (in_data.mask_value <= MASK_THRESHOLD));
        prod_next = PROD_W'(in_data.depth_raw[DEPTH_BITS-1:0]) * PROD_W'(meters_per_unit);
        pos_x = MAG_W'({in_data.pixel_column[COORD_BITS-1:0], 4'b0000});
        pos_y = MAG_W'({in_data.pixel_row[COORD_BITS-1:0], 4'b0000});
        cx    = MAG_W'(center_x);
        cy    = MAG_W'(center_y);
        neg_x1_next = pos_x < cx;
        neg_y1_next = pos_y < cy;
        mag_x1_next = neg_x1_next ? (cx - pos_x) : (pos_x - cx);
        mag_y1_next = neg_y1_next ? (cy - pos_y) : (pos_y - cy);
        rgb1_next = '{red: in_data.red_in, green: in_data.green_in, blue: in_data.blue_in};
    end

    // stage 2
    always_comb begin
        rounded = prod_reg + PROD_W'(128);
        z_full  = rounded[PROD_W-1:8];
        z_pass  = (z_full != '0) && (z_full <= ZF_W'(clip_max_z));
        z2_next = z_full[23:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[0]) begin
            prod_reg   <= prod_next;
            mag_x1_reg <= mag_x1_next;
            mag_y1_reg <= mag_y1_next;
            neg_x1_reg <= neg_x1_next;
            neg_y1_reg <= neg_y1_next;
            rgb1_reg   <= rgb1_next;
        end
        if (ctrl.adv[1]) begin
            z2_reg     <= z2_next;
            mag_x2_reg <= mag_x1_reg;
            mag_y2_reg <= mag_y1_reg;
            neg_x2_reg <= neg_x1_reg;
            neg_y2_reg <= neg_y1_reg;
            rgb2_reg   <= rgb1_reg;
        end
    end

    assign z_out   = z2_reg;
    assign mag_x   = mag_x2_reg;
    assign neg_x   = neg_x2_reg;
    assign mag_y   = mag_y2_reg;
    assign neg_y   = neg_y2_reg;
    assign rgb_out = rgb2_reg;

endmodule

// ===== src/dpb_lateral.sv =====
// one lateral axis: offset times depth times reciprocal focal length, rounded and saturated
module dpb_lateral #(
    parameter int MAG_W = 16
) (
    input  logic                aclk,
    input  dpb_pkg::pipe_ctrl_t ctrl,
    input  logic [MAG_W-1:0]    mag_in,
    input  logic                neg_in,
    input  logic [23:0]         z_in,
    input  logic [23:0]         inv_focal,
    output logic signed [23:0]  coord_out
);
    import dpb_pkg::*;

    localparam int P_W = MAG_W + 24;
    localparam int S_W = P_W + 1;
    localparam int R_W = S_W - 4;

    logic [P_W-1:0]  p_reg, p_next;
    logic [P_W-1:0]  ph_reg, ph_next;
    logic [47:0]     pl_reg, pl_next;
    logic [R_W-1:0]  r_reg, r_next;
    logic [23:0]     coord_reg, coord_next;
    logic            neg3_reg, neg4_reg, neg5_reg;

    logic [48:0]     pl_round;
    logic [S_W-1:0]  sum;
    logic [23:0]     mag_sat;

    always_comb begin
        p_next   = P_W'(mag_in) * P_W'(z_in);
        // split the product so each multiplier stays narrow
        ph_next  = P_W'(p_reg[P_W-1:24]) * P_W'(inv_focal);
        pl_next  = 48'(p_reg[23:0]) * 48'(inv_focal);
        pl_round = {1'b0, pl_reg} + ROUND_HALF;
        sum      = S_W'(ph_reg) + S_W'(pl_round[48:24]);
        r_next   = sum[S_W-1:4];
        if (neg5_reg) begin
            mag_sat    = (r_reg > R_W'(NEG_LIMIT)) ? NEG_LIMIT : r_reg[23:0];
            coord_next = 24'd0 - mag_sat;
        end else begin
            mag_sat    = (r_reg > R_W'(POS_LIMIT)) ? POS_LIMIT : r_reg[23:0];
            coord_next = mag_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[2]) begin
            p_reg    <= p_next;
            neg3_reg <= neg_in;
        end
        if (ctrl.adv[3]) begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            neg4_reg <= neg3_reg;
        end
        if (ctrl.adv[4]) begin
            r_reg    <= r_next;
            neg5_reg <= neg4_reg;
        end
        if (ctrl.adv[5]) begin
            coord_reg <= coord_next;
        end
    end

    assign coord_out = coord_reg;

endmodule

// ===== src/dpb_checker.sv =====
// port-level checker for the back-projection block, bound to the top level
module dpb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input dpb_pkg::out_item_t m_data
);
    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a free output slot always lets a new pixel in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled with output free");

    // zero depth never yields a point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.point_z != 24'd0)
        else $error("point with zero depth");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);
